@@ hw/rtl/sha1_stream_hash_assert.svh @@
// ----------------------------------------------------------------------------
// sha1_stream_hash_assert.svh
// Assertion macros shared by the hash block's modules.
// ----------------------------------------------------------------------------
`ifndef SHA1_STREAM_HASH_ASSERT_SVH
`define SHA1_STREAM_HASH_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define SSH_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("%m: assertion failed");

// Next-cycle implication, checked out of reset.
`define SSH_ASSERT_NXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("%m: assertion failed");

`endif

@@ hw/rtl/sha1sh_pkg.sv @@
// ----------------------------------------------------------------------------
// sha1sh_pkg
// Types, constants and round functions of the SHA-1 stream hash block.
// ----------------------------------------------------------------------------
package sha1sh_pkg;

    typedef logic [4:0][31:0] t_chain;   // element 0 is h0

    localparam t_chain CHAIN_IV = '{
        32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
    };

    localparam logic [31:0] K_R0 = 32'h5A827999;
    localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
    localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
    localparam logic [31:0] K_R3 = 32'hCA62C1D6;

    localparam logic [7:0] PAD_BYTE  = 8'h80;
    localparam logic [6:0] LAST_ROUND = 7'd79;
    localparam logic [5:0] LEN_POS   = 6'd56;   // first byte of the length field
    localparam logic [2:0] LAST_IDX  = 3'd4;
    localparam logic [2:0] MAX_BYTES = 3'd4;

    // One queued item: word, clamped byte count, last mark.
    typedef struct packed {
        logic [31:0] word;
        logic [2:0]  cnt;
        logic        last;
    } t_qent;

    // Requests from the sequencer to the compression unit.
    typedef struct packed {
        logic start;
        logic init;
    } t_core_ctl;

    function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
        logic [63:0] d;
        d = {x, x} << n;
        return d[63:32];
    endfunction

    function automatic logic [31:0] f_round(input logic [6:0] rnd, input logic [31:0] b,
                                            input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        if (rnd < 7'd20) begin
            f = (b & c) | (~b & d);
        end else if (rnd < 7'd40) begin
            f = b ^ c ^ d;
        end else if (rnd < 7'd60) begin
            f = (b & c) | (b & d) | (c & d);
        end else begin
            f = b ^ c ^ d;
        end
        return f;
    endfunction

    function automatic logic [31:0] k_round(input logic [6:0] rnd);
        logic [31:0] k;
        if (rnd < 7'd20) begin
            k = K_R0;
        end else if (rnd < 7'd40) begin
            k = K_R1;
        end else if (rnd < 7'd60) begin
            k = K_R2;
        end else begin
            k = K_R3;
        end
        return k;
    endfunction

endpackage

@@ hw/rtl/sha1sh_front.sv @@
// ----------------------------------------------------------------------------
// sha1sh_front
// Input side: clamps the byte count, drops empty non-last items and queues
// the rest for the block sequencer.
// ----------------------------------------------------------------------------
`include "sha1_stream_hash_assert.svh"

module sha1sh_front
    import sha1sh_pkg::*;
#(
    parameter int DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_bytes_valid,
    input  logic        i_last,
    output logic        o_q_valid,
    output t_qent       o_q_item,
    input  logic        i_q_pop
);

    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    t_qent          r_mem [DEPTH];
    logic [PW-1:0]  r_wptr;
    logic [PW-1:0]  r_rptr;
    logic [CW-1:0]  r_count;
    logic [2:0]     cnt;
    logic           push;
    logic           pop;

    assign cnt     = (i_bytes_valid > MAX_BYTES) ? MAX_BYTES : i_bytes_valid;
    assign o_stall = (r_count == CW'(DEPTH));
    // an empty word that does not end the message changes nothing
    assign push    = i_valid && !o_stall && ((cnt != 3'd0) || i_last);
    assign o_q_valid = (r_count != '0);
    assign pop     = i_q_pop && o_q_valid;
    assign o_q_item = r_mem[r_rptr];

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wptr] <= '{word: i_message_word, cnt: cnt, last: i_last};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wptr <= (r_wptr == PW'(DEPTH - 1)) ? '0 : r_wptr + 1'b1;
            end
            if (pop) begin
                r_rptr <= (r_rptr == PW'(DEPTH - 1)) ? '0 : r_rptr + 1'b1;
            end
            case ({push, pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    `SSH_ASSERT_IMP(a_q_bound, i_clk, i_rst_n, 1'b1, r_count <= CW'(DEPTH))

endmodule

@@ hw/rtl/sha1sh_core.sv @@
// ----------------------------------------------------------------------------
// sha1sh_core
// SHA-1 compression: one round per cycle over a 16-word schedule window,
// then the chaining update.
// ----------------------------------------------------------------------------
`include "sha1_stream_hash_assert.svh"

module sha1sh_core
    import sha1sh_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  t_core_ctl    i_ctl,
    input  logic [511:0] i_block,
    output logic         o_busy,
    output t_chain       o_chain
);

    t_chain            r_h;
    logic [31:0]       r_a, r_b, r_c, r_d, r_e;
    logic [15:0][31:0] r_w;
    logic [6:0]        r_round;
    logic              r_run;
    logic              r_add;
    logic [31:0]       t_sum;

    assign t_sum   = rotl(r_a, 5'd5) + f_round(r_round, r_b, r_c, r_d) + r_e
                     + k_round(r_round) + r_w[0];
    assign o_busy  = r_run || r_add;
    assign o_chain = r_h;

    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
            for (int j = 0; j < 16; j++) begin
                r_w[j] <= i_block[511 - 32*j -: 32];
            end
        end else if (r_run) begin
            r_a <= t_sum;
            r_b <= r_a;
            r_c <= rotl(r_b, 5'd30);
            r_d <= r_c;
            r_e <= r_d;
            for (int j = 0; j < 15; j++) begin
                r_w[j] <= r_w[j+1];
            end
            r_w[15] <= rotl(r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0], 5'd1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run   <= 1'b0;
            r_add   <= 1'b0;
            r_round <= '0;
            r_h     <= CHAIN_IV;
        end else begin
            if (i_ctl.init) begin
                r_h <= CHAIN_IV;
            end
            if (i_ctl.start) begin
                r_run   <= 1'b1;
                r_round <= '0;
            end else if (r_run) begin
                r_round <= r_round + 1'b1;
                if (r_round == LAST_ROUND) begin
                    r_run <= 1'b0;
                    r_add <= 1'b1;
                end
            end else if (r_add) begin
                r_add <= 1'b0;
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end
        end
    end

    `SSH_ASSERT_NXT(a_round_done, i_clk, i_rst_n, r_run && r_round == LAST_ROUND,
                    r_add && !r_run)

endmodule

@@ hw/rtl/sha1sh_back.sv @@
// ----------------------------------------------------------------------------
// sha1sh_back
// Block sequencer: packs queued bytes into the 64-byte block, pads the
// final block, starts compressions and streams out the digest words.
// ----------------------------------------------------------------------------
`include "sha1_stream_hash_assert.svh"

module sha1sh_back
    import sha1sh_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_q_valid,
    input  t_qent        i_q_item,
    output logic         o_q_pop,
    output t_core_ctl    o_core,
    output logic [511:0] o_block,
    input  logic         i_busy,
    input  t_chain       i_chain,
    output logic         o_valid,
    input  logic         i_stall,
    output logic [31:0]  o_digest_word,
    output logic [2:0]   o_word_index,
    output logic         o_digest_last
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_WRITE,
        S_PAD,
        S_PAD2,
        S_FIN,
        S_OUT
    } t_state;

    t_state            r_state;
    logic [63:0][7:0]  r_buf;      // block byte p sits at element 63-p
    logic [63:0][7:0]  n_blk;
    logic [5:0]        r_fill;
    logic [63:0]       r_len;
    logic [31:0]       r_word;
    logic [2:0]        r_cnt;
    logic              r_last;
    logic [2:0]        r_oidx;
    logic              r_ovalid;
    logic [31:0]       r_oword;
    logic [2:0]        r_oidx_out;
    logic              r_olast;

    logic [6:0]        sum;
    logic              full;
    logic [2:0]        spill;
    logic [2:0]        wrote;
    logic              go;
    logic              out_load;
    logic [6:0]        rel;
    logic [31:0]       sh_word;

    assign sum   = {1'b0, r_fill} + {4'b0, r_cnt};
    assign full  = sum[6];
    assign spill = sum[2:0];
    assign wrote = full ? (r_cnt - spill) : r_cnt;
    assign out_load = (r_state == S_OUT) && (!r_ovalid || !i_stall);

    always_comb begin
        n_blk   = r_buf;
        go      = 1'b0;
        rel     = '0;
        sh_word = '0;
        unique case (r_state)
            S_WRITE: begin
                for (int p = 0; p < 64; p++) begin
                    rel     = 7'(p) - {1'b0, r_fill};
                    sh_word = r_word << {rel[1:0], 3'b000};
                    if ((7'(p) >= {1'b0, r_fill}) && (rel < {4'b0, r_cnt})) begin
                        n_blk[63-p] = sh_word[31:24];
                    end
                end
                go = !full || !i_busy;
            end
            S_PAD, S_PAD2: begin
                for (int p = 0; p < 64; p++) begin
                    if (r_state == S_PAD2) begin
                        n_blk[63-p] = 8'h00;
                    end else if (7'(p) == {1'b0, r_fill}) begin
                        n_blk[63-p] = PAD_BYTE;
                    end else if (7'(p) > {1'b0, r_fill}) begin
                        n_blk[63-p] = 8'h00;
                    end
                    // length goes in only when the pad left room for it
                    if ((p >= 56) && ((r_state == S_PAD2) || (r_fill < LEN_POS))) begin
                        n_blk[63-p] = r_len[8*(63-p) +: 8];
                    end
                end
                go = !i_busy;
            end
            default: ;
        endcase
    end

    assign o_block     = n_blk;
    assign o_core.start = go && ((r_state == S_PAD) || (r_state == S_PAD2) ||
                                 ((r_state == S_WRITE) && full));
    assign o_core.init = out_load && (r_oidx == LAST_IDX);
    assign o_q_pop     = (r_state == S_IDLE) && i_q_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_fill   <= '0;
            r_len    <= '0;
            r_oidx   <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (out_load) begin
                r_ovalid <= 1'b1;
            end else if (!i_stall) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_q_valid) begin
                        r_word  <= i_q_item.word;
                        r_cnt   <= i_q_item.cnt;
                        r_last  <= i_q_item.last;
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: begin
                    if (go) begin
                        r_buf  <= n_blk;
                        r_fill <= full ? 6'd0 : sum[5:0];
                        r_len  <= r_len + {58'b0, wrote, 3'b000};
                        if (full && (spill != 3'd0)) begin
                            // rest of the word opens the next block
                            r_word <= r_word << {wrote, 3'b000};
                            r_cnt  <= spill;
                        end else if (r_last) begin
                            r_state <= S_PAD;
                        end else begin
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_PAD: begin
                    if (go) begin
                        r_state <= (r_fill < LEN_POS) ? S_FIN : S_PAD2;
                    end
                end
                S_PAD2: begin
                    if (go) begin
                        r_state <= S_FIN;
                    end
                end
                S_FIN: begin
                    if (!i_busy) begin
                        r_oidx  <= '0;
                        r_state <= S_OUT;
                    end
                end
                S_OUT: begin
                    if (out_load) begin
                        r_oword    <= i_chain[r_oidx];
                        r_oidx_out <= r_oidx;
                        r_olast    <= (r_oidx == LAST_IDX);
                        r_oidx     <= r_oidx + 1'b1;
                        if (r_oidx == LAST_IDX) begin
                            r_fill  <= '0;
                            r_len   <= '0;
                            r_state <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_valid       = r_ovalid;
    assign o_digest_word = r_oword;
    assign o_word_index  = r_oidx_out;
    assign o_digest_last = r_olast;

    `SSH_ASSERT_IMP(a_start_idle, i_clk, i_rst_n, o_core.start, !i_busy)
    `SSH_ASSERT_IMP(a_out_core_idle, i_clk, i_rst_n, r_state == S_OUT, !i_busy)
    `SSH_ASSERT_IMP(a_last_tag, i_clk, i_rst_n, r_ovalid,
                    r_olast == (r_oidx_out == LAST_IDX))

endmodule

@@ hw/rtl/sha1_stream_hash.sv @@
// ----------------------------------------------------------------------------
// sha1_stream_hash
// Streaming SHA-1: byte-counted big-endian words in, five digest words out.
// ----------------------------------------------------------------------------
// Items queue in a short input FIFO; the sequencer moves one queued word at a
// time into the 64-byte block, taking the next only once the last is written,
// and the compression unit runs one round per cycle while the next block
// fills. Sustained rate is therefore set by the compression unit. A last item
// adds one compression (two when fewer than 9 bytes are free after the data)
// plus five digest words out; items of the next message may queue while the
// digest drains.
// ----------------------------------------------------------------------------
module sha1_stream_hash
    import sha1sh_pkg::*;
#(
    parameter int QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_message_word,
    input  logic [2:0]  i_bytes_valid,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_digest_last
);

    logic         q_valid;
    t_qent        q_item;
    logic         q_pop;
    t_core_ctl    core_ctl;
    logic [511:0] core_block;
    logic         core_busy;
    t_chain       chain;

    sha1sh_front #(
        .DEPTH (QUEUE_DEPTH)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_bytes_valid  (i_bytes_valid),
        .i_last         (i_last),
        .o_q_valid      (q_valid),
        .o_q_item       (q_item),
        .i_q_pop        (q_pop)
    );

    sha1sh_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (core_ctl),
        .i_block (core_block),
        .o_busy  (core_busy),
        .o_chain (chain)
    );

    sha1sh_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_q_item      (q_item),
        .o_q_pop       (q_pop),
        .o_core        (core_ctl),
        .o_block       (core_block),
        .i_busy        (core_busy),
        .i_chain       (chain),
        .o_valid       (o_valid),
        .i_stall       (i_stall),
        .o_digest_word (o_digest_word),
        .o_word_index  (o_word_index),
        .o_digest_last (o_digest_last)
    );

endmodule

@@ dv/sha1_stream_hash_tb.sv @@
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sha1_stream_hash_tb
// Drives byte-counted message words into the SHA-1 stream hash and checks
// every digest word against a SHA-1 predictor kept in step with the items.
// ----------------------------------------------------------------------------
module sha1_stream_hash_tb;
    import sha1sh_pkg::*;

    localparam int CLK_HALF     = 6;
    localparam int RESET_CYCLES = 5;
    localparam int DRAIN_CYCLES = 200;     // two compressions plus digest output
    localparam int CYCLE_LIMIT  = 300000;

    typedef struct {
        logic [31:0] word;
        logic [2:0]  pos;
        logic        last;
    } t_digest_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_valid = 1'b0;
    logic        o_stall;
    logic [31:0] i_message_word = '0;
    logic [2:0]  i_bytes_valid = '0;
    logic        i_last = 1'b0;
    logic        o_valid;
    logic        i_stall = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_digest_last;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int error_count = 0;
    int cycle_count = 0;

    // predictor state
    logic [31:0]  hash_h [5];
    logic [31:0]  msg_blk [16];
    int unsigned  blk_fill;
    logic [63:0]  bit_count;
    t_digest_word expected_digests [$];

    sha1_stream_hash uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_message_word (i_message_word),
        .i_bytes_valid  (i_bytes_valid),
        .i_last         (i_last),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_digest_word  (o_digest_word),
        .o_word_index   (o_word_index),
        .o_digest_last  (o_digest_last)
    );

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("FAIL");
        $finish;
    end

    always @(posedge i_clk) begin
        i_stall <= ($urandom_range(99) < stall_pct);
    end

    function automatic void sha_restart();
        for (int i = 0; i < 5; i++) hash_h[i] = CHAIN_IV[i];
        for (int i = 0; i < 16; i++) msg_blk[i] = '0;
        blk_fill = 0;
        bit_count = '0;
    endfunction

    function automatic void sha_compress();
        logic [31:0] w [80];
        logic [31:0] a, b, c, d, e, f, k, t;
        for (int j = 0; j < 16; j++) w[j] = msg_blk[j];
        for (int j = 16; j < 80; j++) begin
            t = w[j-3] ^ w[j-8] ^ w[j-14] ^ w[j-16];
            w[j] = {t[30:0], t[31]};
        end
        a = hash_h[0];
        b = hash_h[1];
        c = hash_h[2];
        d = hash_h[3];
        e = hash_h[4];
        for (int j = 0; j < 80; j++) begin
            if (j < 20) begin
                f = (b & c) | (~b & d);
                k = K_R0;
            end else if (j < 40) begin
                f = b ^ c ^ d;
                k = K_R1;
            end else if (j < 60) begin
                f = (b & c) | (b & d) | (c & d);
                k = K_R2;
            end else begin
                f = b ^ c ^ d;
                k = K_R3;
            end
            t = {a[26:0], a[31:27]} + f + e + k + w[j];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        hash_h[0] += a;
        hash_h[1] += b;
        hash_h[2] += c;
        hash_h[3] += d;
        hash_h[4] += e;
    endfunction

    function automatic void sha_pack_byte(logic [7:0] v);
        int unsigned wi, sh;
        wi = blk_fill / 4;
        sh = (3 - blk_fill % 4) * 8;
        msg_blk[wi][sh +: 8] = v;
        blk_fill++;
        if (blk_fill == 64) begin
            sha_compress();
            blk_fill = 0;
        end
    endfunction

    // Absorb one accepted item; a last item queues the five digest words.
    function automatic void sha_absorb_item(logic [31:0] w, logic [2:0] n, logic l);
        int unsigned cnt;
        t_digest_word dw;
        cnt = (n > MAX_BYTES) ? MAX_BYTES : n;
        for (int i = 0; i < cnt; i++) begin
            sha_pack_byte(w[31 - 8*i -: 8]);
            bit_count += 64'd8;
        end
        if (!l) return;
        sha_pack_byte(PAD_BYTE);
        while (blk_fill != LEN_POS) sha_pack_byte(8'h00);
        msg_blk[14] = bit_count[63:32];
        msg_blk[15] = bit_count[31:0];
        sha_compress();
        for (int r = 0; r < 5; r++) begin
            dw.word = hash_h[r];
            dw.pos  = 3'(r);
            dw.last = (3'(r) == LAST_IDX);
            expected_digests.insert(expected_digests.size(), dw);
        end
        sha_restart();
    endfunction

    always @(posedge i_clk) begin : check_digest
        t_digest_word exp_d;
        if (i_rst_n && o_valid && !i_stall) begin
            if (expected_digests.size() == 0) begin
                $error("digest_word 0x%08h arrived with nothing pending", o_digest_word);
                error_count++;
            end else begin
                exp_d = expected_digests.pop_front();
                if (o_digest_word !== exp_d.word) begin
                    $error("digest_word: expected 0x%08h, got 0x%08h",
                           exp_d.word, o_digest_word);
                    error_count++;
                end
                if (o_word_index !== exp_d.pos) begin
                    $error("word_index: expected %0d, got %0d", exp_d.pos, o_word_index);
                    error_count++;
                end
                if (o_digest_last !== exp_d.last) begin
                    $error("digest_last: expected %0d, got %0d", exp_d.last, o_digest_last);
                    error_count++;
                end
            end
        end
    end

    // Called at a rising edge; returns at the edge that accepts the item.
    task automatic send_item(logic [31:0] w, logic [2:0] n, logic l);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_valid        <= 1'b1;
        i_message_word <= w;
        i_bytes_valid  <= n;
        i_last         <= l;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        sha_absorb_item(w, n, l);
    endtask

    task automatic test_empty_message();
        send_item(32'h0000_0000, 3'd0, 1'b1);
    endtask

    task automatic test_short_messages();
        send_item(32'h6162_6300, 3'd3, 1'b1);   // "abc"
        send_item(32'hFFFF_FFFF, MAX_BYTES, 1'b1);
    endtask

    // Oversized counts, a zero-byte word mid-message, odd partial words.
    task automatic test_byte_counts();
        send_item(32'hDEAD_BEEF, 3'd7, 1'b0);
        send_item(32'h0123_4567, 3'd5, 1'b0);
        send_item(32'hFFFF_FFFF, 3'd0, 1'b0);
        send_item(32'hA5C3_5A3C, 3'd2, 1'b0);
        send_item(32'h8899_AABB, 3'd1, 1'b0);
        send_item(32'h55AA_55AA, 3'd6, 1'b1);
    endtask

    // 56 data bytes leave no room for the length: two final blocks.
    task automatic test_two_block_pad();
        for (int i = 0; i < 13; i++) send_item($urandom, MAX_BYTES, 1'b0);
        send_item($urandom, MAX_BYTES, 1'b1);
    endtask

    task automatic test_random_messages(int n_items);
        int sent;
        int words;
        logic [2:0] n;
        sent = 0;
        while (sent < n_items) begin
            words = ($urandom_range(9) == 0) ? $urandom_range(40, 17) : $urandom_range(16, 0);
            for (int i = 0; i < words; i++) begin
                if ($urandom_range(19) == 0) send_item($urandom, 3'd0, 1'b0);
                n = ($urandom_range(3) == 0) ? 3'($urandom_range(7, 1)) : MAX_BYTES;
                send_item($urandom, n, 1'b0);
                sent++;
            end
            send_item($urandom, 3'($urandom_range(7, 0)), 1'b1);
            sent++;
        end
    endtask

    initial begin
        sha_restart();
        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        send_idle_pct = 10;
        stall_pct     = 81;
        test_empty_message();
        test_short_messages();
        test_byte_counts();
        test_two_block_pad();
        test_random_messages(20);

        send_idle_pct = 81;
        stall_pct     = 10;
        test_random_messages(20);

        send_idle_pct = 0;
        stall_pct     = 0;
        test_random_messages(20);

        i_valid <= 1'b0;
        while (expected_digests.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);

        if (error_count == 0 && expected_digests.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule
